// ===== sv/pbt_pkg.sv =====
// pbt_pkg: shared constants, types and state codes of the head-count block
// depends on: nothing
package pbt_pkg;

  // sizing of the distribution and of the fixed-point formats
  localparam int MAX_COINS      = 1024;
  localparam int PROB_FRAC_BITS = 16;
  localparam int DIST_FRAC_BITS = 31;

  localparam int PROB_W  = PROB_FRAC_BITS + 1;
  localparam int DIST_W  = DIST_FRAC_BITS + 1;
  localparam int COUNT_W = 11;
  localparam int AW      = $clog2(MAX_COINS + 1);
  localparam int JW      = $clog2(MAX_COINS + 2);
  localparam int PROD_W  = DIST_W + PROB_W;
  localparam int ACC_W   = DIST_W + AW;

  localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};
  localparam logic [DIST_W-1:0] DIST_ONE = {1'b1, {DIST_FRAC_BITS{1'b0}}};

  // control states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } pbt_state_t;

  // one pass over the distribution
  typedef struct packed {
    logic              start;
    logic [AW-1:0]     base;    // coins counted before this pass
    logic [PROB_W-1:0] q;       // weight of the same entry
    logic [PROB_W-1:0] p;       // weight of the entry below
    logic              wr_en;   // write blended entries back
    logic              tally;   // sum the upper tail
    logic [AW-1:0]     total;   // coin count for the tail test
  } pbt_cmd_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] sum;
  } pbt_sts_t;

endpackage

// ===== sv/pbt_coin_if.sv =====
// pbt_coin_if: input channel, one coin per beat
// depends on: pbt_pkg
interface pbt_coin_if import pbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] prob;
  logic              last;

  modport source (output valid, output prob, output last, input ready);
  modport sink (input valid, input prob, input last, output ready);
endinterface

// ===== sv/pbt_result_if.sv =====
// pbt_result_if: result channel, one tail probability per beat
// depends on: pbt_pkg
interface pbt_result_if import pbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  tail_prob;
  logic [COUNT_W-1:0] coin_count;
  logic               overflowed;

  modport source (output valid, output tail_prob, output coin_count, output overflowed,
                  input ready);
  modport sink (input valid, input tail_prob, input coin_count, input overflowed,
                output ready);
endinterface

// ===== sv/pbt_engine.sv =====
// pbt_engine: distribution memory with a read-blend-write pipeline and tail sum
// depends on: pbt_pkg
module pbt_engine import pbt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  pbt_cmd_t cmd,
  output pbt_sts_t sts
);

  // distribution store, entries above the count are never read
  logic [DIST_W-1:0] mem [0:MAX_COINS];
  logic [DIST_W-1:0] rd_data;

  // pass settings held for the whole pass
  logic [AW-1:0]     base;
  logic [PROB_W-1:0] q;
  logic [PROB_W-1:0] p;
  logic              wr_en;
  logic              tally;
  logic [AW-1:0]     total;

  // issue stage
  logic          run;
  logic          a_first;
  logic [JW-1:0] jr;
  logic [JW-1:0] rd_idx;

  // read data stage
  logic          b_vld;
  logic [JW-1:0] b_j;
  logic          b_first;
  logic          b_zero;
  logic          b_subst;
  logic [DIST_W-1:0] b_val;
  logic [DIST_W-1:0] a_val;
  logic [DIST_W-1:0] prev_b;

  // product stage
  logic              c_vld;
  logic [JW-1:0]     c_j;
  logic [PROD_W-1:0] pa;
  logic [PROD_W-1:0] pb;
  logic [PROD_W:0]   blend_sum;
  logic [DIST_W-1:0] blend;
  logic              in_tail;

  logic             done;
  logic [ACC_W-1:0] acc;

  assign rd_idx = jr - JW'(1);

  // latch pass settings
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      base  <= cmd.base;
      q     <= cmd.q;
      p     <= cmd.p;
      wr_en <= cmd.wr_en;
      tally <= cmd.tally;
      total <= cmd.total;
    end
  end

  // step counter, descending from base+1 to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      run     <= 1'b0;
      a_first <= 1'b0;
      jr      <= '0;
    end else if (cmd.start) begin
      run     <= 1'b1;
      a_first <= 1'b1;
      jr      <= JW'(cmd.base) + JW'(1);
    end else if (run) begin
      a_first <= 1'b0;
      if (jr == '0) begin
        run <= 1'b0;
      end else begin
        jr <= rd_idx;
      end
    end
  end

  // memory: read entry j-1, write the blended entry j
  always_ff @(posedge clk) begin
    if (c_vld && wr_en) begin
      mem[c_j[AW-1:0]] <= blend;
    end
    if (run && jr != '0) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  // stage b control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= run;
    end
  end

  always_ff @(posedge clk) begin
    b_j     <= jr;
    b_first <= a_first;
    b_zero  <= (jr == '0);
    b_subst <= (jr == JW'(1)) && (base == '0);
  end

  // upper operand is the previous step's lower operand
  always_comb begin
    if (b_zero) begin
      b_val = '0;
    end else if (b_subst) begin
      b_val = DIST_ONE;
    end else begin
      b_val = rd_data;
    end
    a_val = b_first ? '0 : prev_b;
  end

  // products, registered
  always_ff @(posedge clk) begin
    if (b_vld) begin
      prev_b <= b_val;
    end
    pa  <= PROD_W'(a_val) * PROD_W'(q);
    pb  <= PROD_W'(b_val) * PROD_W'(p);
    c_j <= b_j;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      c_vld <= b_vld;
      done  <= c_vld && (c_j == '0);
    end
  end

  // blend and tail test
  always_comb begin
    blend_sum = {1'b0, pa} + {1'b0, pb};
    blend     = blend_sum[PROB_FRAC_BITS +: DIST_W];
    in_tail   = {c_j, 1'b0} > (JW + 1)'(total);
  end

  // tail accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= '0;
    end else if (c_vld && tally && in_tail) begin
      acc <= acc + ACC_W'(blend);
    end
  end

  assign sts.done = done;
  assign sts.sum  = acc;

endmodule

// ===== sv/poisson_binomial_tail_top.sv =====
// poisson_binomial_tail_top: coin intake, set bookkeeping and result register
// depends on: pbt_pkg, pbt_coin_if, pbt_result_if, pbt_engine
//
// Each coin beat carries a heads probability (Q1.16, values above 1.0 taken as
// 1.0) and folds it into a head-count distribution held in one 1025-entry
// memory of Q1.31 values. A coin walks the memory once, from entry n+1 down to
// entry 0, one entry per cycle through a read, multiply and write-back
// pipeline, n being the coins already counted in the set; no new coin is taken
// until the walk is done. A coin beyond MAX_COINS is dropped and flagged,
// unless it carries last, in which case a read-only walk of the full memory
// gathers the tail. On last the block returns P(heads > tails), saturated at
// 1.0, with the coin count and overflow flag, and starts a new set. A finished
// result waits in an output register while the next coin is taken. No clearing
// pass is needed after reset.
module poisson_binomial_tail_top import pbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  pbt_coin_if.sink     coin,
  pbt_result_if.source result
);

  pbt_state_t state;
  pbt_state_t state_next;

  pbt_cmd_t cmd;
  pbt_sts_t sts;

  logic [AW-1:0] coins_seen;
  logic          overflow_flag;
  logic [AW-1:0] res_count;
  logic          res_ovf;
  logic          res_want;

  logic               out_vld;
  logic [DIST_W-1:0]  out_tail;
  logic [COUNT_W-1:0] out_count;
  logic               out_ovf;

  logic              take;
  logic              full;
  logic              slot_free;
  logic              load;
  logic [PROB_W-1:0] p_sat;
  logic [DIST_W-1:0] tail_sat;

  pbt_engine u_engine (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

  assign take      = coin.valid && coin.ready;
  assign full      = (coins_seen == AW'(MAX_COINS));
  assign slot_free = !out_vld || result.ready;
  assign p_sat     = (coin.prob > PROB_ONE) ? PROB_ONE : coin.prob;
  assign tail_sat  = (sts.sum > ACC_W'(DIST_ONE)) ? DIST_ONE : sts.sum[DIST_W-1:0];

  // next state and handshake
  always_comb begin
    state_next = state;
    coin.ready = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        coin.ready = 1'b1;
        if (coin.valid && (!full || coin.last)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.done) begin
          if (!res_want) begin
            state_next = ST_IDLE;
          end else if (slot_free) begin
            load       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // set bookkeeping, pass commands and result fields of the set
  always_ff @(posedge clk) begin
    if (rst) begin
      coins_seen    <= '0;
      overflow_flag <= 1'b0;
      res_want      <= 1'b0;
      cmd.start     <= 1'b0;
    end else begin
      cmd.start <= 1'b0;
      if (take) begin
        res_want <= coin.last;
        if (full) begin
          // coin past the limit: distribution unchanged
          overflow_flag <= 1'b1;
          cmd.base      <= coins_seen;
          cmd.q         <= PROB_ONE;
          cmd.p         <= '0;
          cmd.wr_en     <= 1'b0;
          cmd.tally     <= 1'b1;
          cmd.total     <= coins_seen;
          res_count     <= coins_seen;
          res_ovf       <= 1'b1;
          if (coin.last) begin
            cmd.start     <= 1'b1;
            coins_seen    <= '0;
            overflow_flag <= 1'b0;
          end
        end else begin
          cmd.start  <= 1'b1;
          cmd.base   <= coins_seen;
          cmd.q      <= PROB_ONE - p_sat;
          cmd.p      <= p_sat;
          cmd.wr_en  <= 1'b1;
          cmd.tally  <= coin.last;
          cmd.total  <= coins_seen + AW'(1);
          res_count  <= coins_seen + AW'(1);
          res_ovf    <= overflow_flag;
          coins_seen <= coins_seen + AW'(1);
          if (coin.last) begin
            coins_seen    <= '0;
            overflow_flag <= 1'b0;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tail  <= tail_sat;
      out_count <= COUNT_W'(res_count);
      out_ovf   <= res_ovf;
    end
  end

  assign result.valid      = out_vld;
  assign result.tail_prob  = out_tail;
  assign result.coin_count = out_count;
  assign result.overflowed = out_ovf;

endmodule
